FILE: rtl/core/cv3_pkg.sv
package cv3_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int COEF_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 8;

  localparam int PIX_W     = 8;
  localparam int PIXEL_W   = 3 * PIX_W;
  localparam int ROW_W     = 12;
  localparam int COL_OUT_W = 11;
  localparam int LW_REG_W  = 12;
  localparam int CREG_W    = 48;
  localparam int APB_AW    = 6;
  localparam int APB_DW    = 64;
  localparam int IDX_W     = 3;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam logic [ROW_W-1:0] ROW_SAT = 12'd4095;

  localparam logic [IDX_W-1:0] REG_COLOR_MODE = 3'd0;
  localparam logic [IDX_W-1:0] REG_LINE_WIDTH = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_ROW0  = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_ROW1  = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF_ROW2  = 3'd4;

  localparam logic [LW_REG_W-1:0] LINE_WIDTH_RST = 12'd2048;
  localparam logic [CREG_W-1:0]   COEF_ROW0_RST  = 48'd0;
  localparam logic [CREG_W-1:0]   COEF_ROW1_RST  = 48'd256;
  localparam logic [CREG_W-1:0]   COEF_ROW2_RST  = 48'd0;

  typedef struct packed {
    logic                         color_mode;
    logic [LW_REG_W-1:0]          line_width;
    logic [2:0][CREG_W-1:0]       coef_row;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } meta_t;

endpackage

FILE: rtl/core/cv3_pix_if.sv
interface cv3_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic       start_of_frame;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  output start_of_frame, input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue,
                input start_of_frame, output ready);
endinterface

FILE: rtl/core/cv3_res_if.sv
interface cv3_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [11:0] center_row;
  logic [10:0] center_col;
  logic        end_of_line;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output center_row, output center_col, output end_of_line,
                  input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input center_row, input center_col, input end_of_line,
                output ready);
endinterface

FILE: rtl/core/cv3_ram.sv
module cv3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/cv3_regs.sv
module cv3_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cv3_pkg::APB_AW-1:0]  paddr,
  input  logic [cv3_pkg::APB_DW-1:0]  pwdata,
  output logic [cv3_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output cv3_pkg::cfg_t               cfg
);

  logic [cv3_pkg::IDX_W-1:0] idx;
  logic                      wr;

  assign pready = 1'b1;
  assign idx    = paddr[cv3_pkg::APB_AW-1:3];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_mode  <= 1'b0;
      cfg.line_width  <= cv3_pkg::LINE_WIDTH_RST;
      cfg.coef_row[0] <= cv3_pkg::COEF_ROW0_RST;
      cfg.coef_row[1] <= cv3_pkg::COEF_ROW1_RST;
      cfg.coef_row[2] <= cv3_pkg::COEF_ROW2_RST;
    end else if (wr) begin
      unique case (idx)
        cv3_pkg::REG_COLOR_MODE: cfg.color_mode  <= pwdata[0];
        cv3_pkg::REG_LINE_WIDTH: cfg.line_width  <= pwdata[cv3_pkg::LW_REG_W-1:0];
        cv3_pkg::REG_COEF_ROW0:  cfg.coef_row[0] <= pwdata[cv3_pkg::CREG_W-1:0];
        cv3_pkg::REG_COEF_ROW1:  cfg.coef_row[1] <= pwdata[cv3_pkg::CREG_W-1:0];
        cv3_pkg::REG_COEF_ROW2:  cfg.coef_row[2] <= pwdata[cv3_pkg::CREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cv3_pkg::REG_COLOR_MODE: prdata = cv3_pkg::APB_DW'(cfg.color_mode);
      cv3_pkg::REG_LINE_WIDTH: prdata = cv3_pkg::APB_DW'(cfg.line_width);
      cv3_pkg::REG_COEF_ROW0:  prdata = cv3_pkg::APB_DW'(cfg.coef_row[0]);
      cv3_pkg::REG_COEF_ROW1:  prdata = cv3_pkg::APB_DW'(cfg.coef_row[1]);
      cv3_pkg::REG_COEF_ROW2:  prdata = cv3_pkg::APB_DW'(cfg.coef_row[2]);
      default:                 prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/cv3_lane.sv
module cv3_lane #(
  parameter int COEF_BITS = cv3_pkg::COEF_BITS_DEF,
  parameter int FRAC_BITS = cv3_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [cv3_pkg::PIX_W-1:0]   px [9],
  input  logic signed [COEF_BITS-1:0] coef [9],
  output logic [cv3_pkg::PIX_W-1:0]   res
);

  localparam int PW = COEF_BITS + cv3_pkg::PIX_W + 1;
  localparam int RW = PW + 2;
  localparam int SW = PW + 4;

  logic signed [PW-1:0] pe [9];
  logic signed [PW-1:0] ce [9];
  logic signed [PW-1:0] prod [9];
  logic signed [RW-1:0] rsum [3];
  logic signed [SW-1:0] total;
  logic [SW-1:0]        q;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      pe[i] = PW'(px[i]);
      ce[i] = {{(PW-COEF_BITS){coef[i][COEF_BITS-1]}}, coef[i]};
    end
  end

  // tap products, then row sums, then total and clamp
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        prod[i] <= pe[i] * ce[i];
      end
      for (int r = 0; r < 3; r++) begin
        rsum[r] <= RW'(prod[3*r]) + RW'(prod[3*r+1]) + RW'(prod[3*r+2]);
      end
      if (total[SW-1]) begin
        res <= '0;
      end else if (q > SW'(cv3_pkg::PIX_MAX)) begin
        res <= cv3_pkg::PIX_MAX;
      end else begin
        res <= q[cv3_pkg::PIX_W-1:0];
      end
    end
  end

  assign total = SW'(rsum[0]) + SW'(rsum[1]) + SW'(rsum[2]);
  assign q     = $unsigned(total) >> FRAC_BITS;

endmodule

FILE: rtl/core/cv3_merge.sv
module cv3_merge (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vld,
  input  cv3_pkg::meta_t            meta,
  input  logic                      color_mode,
  input  logic [cv3_pkg::PIX_W-1:0] res_r,
  input  logic [cv3_pkg::PIX_W-1:0] res_g,
  input  logic [cv3_pkg::PIX_W-1:0] res_b,
  cv3_res_if.source                 res
);

  logic                      out_valid;
  logic [cv3_pkg::PIX_W-1:0] red;
  logic [cv3_pkg::PIX_W-1:0] green;
  logic [cv3_pkg::PIX_W-1:0] blue;
  cv3_pkg::meta_t            meta_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld;
    end
  end

  // gray mode keeps only the red lane
  always_ff @(posedge clk) begin
    if (en) begin
      red    <= res_r;
      green  <= color_mode ? res_g : '0;
      blue   <= color_mode ? res_b : '0;
      meta_q <= meta;
    end
  end

  assign res.valid       = out_valid;
  assign res.out_red     = red;
  assign res.out_green   = green;
  assign res.out_blue    = blue;
  assign res.center_row  = meta_q.row;
  assign res.center_col  = meta_q.col;
  assign res.end_of_line = meta_q.last;

endmodule

FILE: rtl/core/conv3x3_rgb_gray_clamp_unit.sv
// a result passes stage 1, the window, lane products, row sums, clamp and merge register
// throughput: one pixel per clock unless stalled; line store read, written once per pixel
// backpressure on the result side stalls the whole pipeline, pixels are taken when it moves
// reset: synchronous; clears counters, window, pipeline valids and config registers
// line store contents are not cleared; only rows written in the current frame are used
module conv3x3_rgb_gray_clamp_unit #(
  parameter int MAX_WIDTH = cv3_pkg::MAX_WIDTH_DEF,
  parameter int COEF_BITS = cv3_pkg::COEF_BITS_DEF,
  parameter int FRAC_BITS = cv3_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  cv3_pix_if.sink                    pix_in,
  cv3_res_if.source                  res_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cv3_pkg::APB_AW-1:0] paddr,
  input  logic [cv3_pkg::APB_DW-1:0] pwdata,
  output logic [cv3_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int LW   = ((CW + 1 > cv3_pkg::LW_REG_W) ? CW + 1 : cv3_pkg::LW_REG_W) + 1;
  localparam int PXW  = cv3_pkg::PIXEL_W;
  localparam int EXTW = (3 * COEF_BITS > cv3_pkg::CREG_W) ? 3 * COEF_BITS : cv3_pkg::CREG_W;
  localparam int ROW_W = cv3_pkg::ROW_W;

  cv3_pkg::cfg_t cfg;

  cv3_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic adv;
  logic acc;

  assign adv          = !res_out.valid || res_out.ready;
  assign pix_in.ready = adv;
  assign acc          = pix_in.valid && adv;

  // column / row tracking
  logic [CW-1:0]    col_count;
  logic [CW-1:0]    col_count_next;
  logic [ROW_W-1:0] row_count;
  logic [ROW_W-1:0] row_count_next;
  logic [CW-1:0]    col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [LW-1:0]    lw_ext;
  logic [LW-1:0]    wclamp;
  logic [LW-1:0]    wm1;
  logic             last;
  logic             emit;
  logic [CW-1:0]    col_m1;
  logic [PXW-1:0]   pix;

  assign col_cur = pix_in.start_of_frame ? '0 : col_count;
  assign row_cur = pix_in.start_of_frame ? '0 : row_count;
  assign lw_ext  = LW'(cfg.line_width);
  assign wm1     = wclamp - LW'(1);
  assign last    = LW'(col_cur) >= wm1;
  assign emit    = (row_cur >= ROW_W'(2)) && (col_cur >= CW'(2));
  assign col_m1  = col_cur - CW'(1);
  assign pix     = {pix_in.in_blue, pix_in.in_green, pix_in.in_red};

  always_comb begin
    if (lw_ext < LW'(3)) begin
      wclamp = LW'(3);
    end else if (lw_ext > LW'(MAX_WIDTH)) begin
      wclamp = LW'(MAX_WIDTH);
    end else begin
      wclamp = lw_ext;
    end
  end

  always_comb begin
    col_count_next = col_count;
    row_count_next = row_count;
    if (acc) begin
      if (last) begin
        col_count_next = '0;
        row_count_next = (row_cur < cv3_pkg::ROW_SAT) ? row_cur + ROW_W'(1) : row_cur;
      end else begin
        col_count_next = col_cur + CW'(1);
        row_count_next = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // stage 1: line store read returns, entry holds {two rows above, row above}
  logic           v1;
  logic           emit1;
  logic [CW-1:0]  col1;
  logic [PXW-1:0] pix1;
  cv3_pkg::meta_t meta1;
  logic           we;
  logic [2*PXW-1:0] ram_q;
  logic [2*PXW-1:0] wdata;
  logic [2*PXW-1:0] q1;
  logic             fwd;
  logic [2*PXW-1:0] fwd_data;
  logic [PXW-1:0]   mid;
  logic [PXW-1:0]   top;

  assign we    = adv && v1;
  assign q1    = fwd ? fwd_data : ram_q;
  assign mid   = q1[PXW-1:0];
  assign top   = q1[2*PXW-1:PXW];
  assign wdata = {mid, pix1};

  cv3_ram #(
    .WIDTH (2 * PXW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (we),
    .waddr (col1),
    .wdata (wdata),
    .re    (acc),
    .raddr (col_cur),
    .rdata (ram_q)
  );

  // same column written back while read: take the new data
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (acc) begin
      fwd <= we && (col1 == col_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fwd_data <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      emit1      <= emit;
      col1       <= col_cur;
      pix1       <= pix;
      meta1.row  <= row_cur - ROW_W'(1);
      meta1.col  <= cv3_pkg::COL_OUT_W'(col_m1);
      meta1.last <= last;
    end
  end

  // stage 2: 3x3 window
  logic [PXW-1:0] win [3][3];
  logic           v2;
  cv3_pkg::meta_t meta2;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          win[y][x] <= '0;
        end
      end
    end else if (we) begin
      for (int y = 0; y < 3; y++) begin
        win[y][0] <= win[y][1];
        win[y][1] <= win[y][2];
      end
      win[0][2] <= top;
      win[1][2] <= mid;
      win[2][2] <= pix1;
    end
  end

  // coefficient for window tap (y,x) is kernel (2-y,2-x)
  logic [EXTW-1:0]             cext [3];
  logic signed [COEF_BITS-1:0] kc [9];
  logic [cv3_pkg::PIX_W-1:0]   lane_px [3][9];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      cext[r] = EXTW'(cfg.coef_row[r]);
    end
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 3; x++) begin
        kc[y*3+x] = cext[2-y][(2-x)*COEF_BITS +: COEF_BITS];
        for (int ch = 0; ch < 3; ch++) begin
          lane_px[ch][y*3+x] = win[y][x][ch*cv3_pkg::PIX_W +: cv3_pkg::PIX_W];
        end
      end
    end
  end

  // valid and position ride alongside the lane stages
  logic           v3;
  logic           v4;
  logic           v5;
  cv3_pkg::meta_t meta3;
  cv3_pkg::meta_t meta4;
  cv3_pkg::meta_t meta5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v2 <= v1 && emit1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta2 <= meta1;
      meta3 <= meta2;
      meta4 <= meta3;
      meta5 <= meta4;
    end
  end

  logic [cv3_pkg::PIX_W-1:0] lane_res [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    cv3_lane #(
      .COEF_BITS (COEF_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .en   (adv),
      .px   (lane_px[ch]),
      .coef (kc),
      .res  (lane_res[ch])
    );
  end

  cv3_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .vld        (v5),
    .meta       (meta5),
    .color_mode (cfg.color_mode),
    .res_r      (lane_res[0]),
    .res_g      (lane_res[1]),
    .res_b      (lane_res[2]),
    .res        (res_out)
  );

  a_acc_fills_stage1 : assert property (@(posedge clk) disable iff (rst)
    acc |=> v1)
    else $error("accepted pixel did not reach stage 1");

  a_emit_reaches_window : assert property (@(posedge clk) disable iff (rst)
    (v1 && emit1 && adv) |=> v2)
    else $error("interior pixel dropped at window stage");

  a_center_row_interior : assert property (@(posedge clk) disable iff (rst)
    res_out.valid |-> (res_out.center_row != '0))
    else $error("result on border row");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !res_out.valid |-> pix_in.ready)
    else $error("input stalled with empty output register");

endmodule
